// ----- hdl/qmm_pkg.sv -----
// ----------------------------------------------------------------------------
// qmm_pkg: shared types and constants of the quadrotor motor mixer
// Request and response payloads, register indexes and datapath widths.
// ----------------------------------------------------------------------------
package qmm_pkg;

   // Request fields.
   localparam int FIELD_W = 24;

   // Shifted yaw can grow by up to seven bits, and halving drops one.
   localparam int YAW_SHIFT_W = 3;
   localparam int YAW_EXT_W   = FIELD_W + (1 << YAW_SHIFT_W) - 1;
   localparam int HALF_YAW_W  = YAW_EXT_W - 1;
   localparam int HALF_LIFT_W = FIELD_W - 1;

   // Squared-speed sums and the square root.
   localparam int SUM_W  = 32;
   localparam int RAD_W  = 32;
   localparam int ROOT_W = 16;

   // Square-root steps per pipeline stage (divides ROOT_W).
   localparam int SQRT_STEPS_PER_STAGE = 2;

   localparam int MOTORS = 4;

   // Control registers.
   localparam int THRUST_SHIFT_W = 4;
   localparam int SPEED_W        = 16;
   localparam int CSR_INDEX_W    = 2;
   localparam int CSR_DATA_W     = 16;

   localparam logic [CSR_INDEX_W-1:0] REG_THRUST_SHIFT = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_YAW_SHIFT    = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_MIN_SPEED    = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_MAX_SPEED    = 2'd3;

   localparam logic [SPEED_W-1:0] MAX_SPEED_RESET = 16'hFFFF;

   typedef struct packed {
      logic        [FIELD_W-1:0] lift;
      logic signed [FIELD_W-1:0] roll_moment;
      logic signed [FIELD_W-1:0] pitch_moment;
      logic signed [FIELD_W-1:0] yaw_moment;
      logic                      stick_lift_zero;
   } req_type;

   typedef struct packed {
      logic [SPEED_W-1:0] motor_0;
      logic [SPEED_W-1:0] motor_1;
      logic [SPEED_W-1:0] motor_2;
      logic [SPEED_W-1:0] motor_3;
   } rsp_type;

endpackage

// ----- hdl/qmm_sqrt_pipe.sv -----
// ----------------------------------------------------------------------------
// qmm_sqrt_pipe: pipelined floor integer square root
// Digit-by-digit restoring square root, STEPS result bits per register stage.
// ----------------------------------------------------------------------------
module qmm_sqrt_pipe #(
   parameter int STEPS = qmm_pkg::SQRT_STEPS_PER_STAGE
) (
   input  logic                        clock,
   input  logic [qmm_pkg::RAD_W-1:0]   rad_i,
   output logic [qmm_pkg::ROOT_W-1:0]  root_o
);

   localparam int RAD_W  = qmm_pkg::RAD_W;
   localparam int ROOT_W = qmm_pkg::ROOT_W;
   localparam int REM_W  = ROOT_W + 1;
   localparam int STAGES = ROOT_W / STEPS;

   logic [RAD_W-1:0]  rad_ff  [STAGES];
   logic [RAD_W-1:0]  rad_in  [STAGES];
   logic [REM_W-1:0]  rem_ff  [STAGES];
   logic [REM_W-1:0]  rem_in  [STAGES];
   logic [ROOT_W-1:0] root_ff [STAGES];
   logic [ROOT_W-1:0] root_in [STAGES];

   always_comb begin
      logic [RAD_W-1:0]  rad;
      logic [REM_W-1:0]  rem;
      logic [ROOT_W-1:0] root;
      logic [REM_W+1:0]  cur;
      logic [REM_W+1:0]  trial;
      for (int s = 0; s < STAGES; s++) begin
         if (s == 0) begin
            rad  = rad_i;
            rem  = '0;
            root = '0;
         end else begin
            rad  = rad_ff[s-1];
            rem  = rem_ff[s-1];
            root = root_ff[s-1];
         end
         for (int k = 0; k < STEPS; k++) begin
            // Bring down the next two radicand bits and try the 4*root+1 subtrahend.
            cur   = {rem, rad[RAD_W-1 -: 2]};
            rad   = rad << 2;
            trial = {1'b0, root, 2'b01};
            if (cur >= trial) begin
               cur  = cur - trial;
               root = {root[ROOT_W-2:0], 1'b1};
            end else begin
               root = {root[ROOT_W-2:0], 1'b0};
            end
            rem = cur[REM_W-1:0];
         end
         rad_in[s]  = rad;
         rem_in[s]  = rem;
         root_in[s] = root;
      end
   end

   always_ff @(posedge clock) begin
      for (int s = 0; s < STAGES; s++) begin
         rad_ff[s]  <= rad_in[s];
         rem_ff[s]  <= rem_in[s];
         root_ff[s] <= root_in[s];
      end
   end

   assign root_o = root_ff[STAGES-1];

endmodule

// ----- hdl/quadrotor_motor_mixer_sqrt.sv -----
// ----------------------------------------------------------------------------
// quadrotor_motor_mixer_sqrt: four-motor mixer with square-root speed stage
// Mixes lift, roll, pitch and yaw demands into four motor speeds.
// ----------------------------------------------------------------------------
// Usage:
// A request is taken at a rising edge with start high and busy low. busy is
// high only while reset is asserted, so a new request can enter every cycle.
// Each request yields one response: rsp_valid is high for exactly one cycle
// with the four motor speeds on rsp_data. The receiver cannot stall.
// A request passes the scaling stage, the sum stage, the square-root stages
// and the output register; throughput is one request per cycle. The depth
// is set by the square-root pipeline, which retires SQRT_STEPS result bits
// per stage in each motor lane.
// Control registers are written through csr_we/csr_index/csr_wdata and take
// effect at once; they are meant to be written while no request is in flight.
// Synchronous reset empties the pipeline, drops all in-flight requests and
// returns the registers to their defaults (no shifts, minimum speed 0,
// maximum speed 65535).
// ----------------------------------------------------------------------------
module quadrotor_motor_mixer_sqrt #(
   parameter int SQRT_STEPS = qmm_pkg::SQRT_STEPS_PER_STAGE
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  qmm_pkg::req_type                  req_data,
   output logic                              rsp_valid,
   output qmm_pkg::rsp_type                  rsp_data,
   input  logic                              csr_we,
   input  logic [qmm_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [qmm_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   localparam int FIELD_W     = qmm_pkg::FIELD_W;
   localparam int YAW_EXT_W   = qmm_pkg::YAW_EXT_W;
   localparam int HALF_YAW_W  = qmm_pkg::HALF_YAW_W;
   localparam int HALF_LIFT_W = qmm_pkg::HALF_LIFT_W;
   localparam int SUM_W       = qmm_pkg::SUM_W;
   localparam int RAD_W       = qmm_pkg::RAD_W;
   localparam int ROOT_W      = qmm_pkg::ROOT_W;
   localparam int SPEED_W     = qmm_pkg::SPEED_W;
   localparam int MOTORS      = qmm_pkg::MOTORS;
   localparam int STAGES      = ROOT_W / SQRT_STEPS;
   localparam int PIPE_D      = STAGES + 2;
   localparam int LATENCY     = PIPE_D + 1;

   // ------------------------------------------------------------------
   // Control registers
   // ------------------------------------------------------------------
   logic [qmm_pkg::THRUST_SHIFT_W-1:0] thrust_shift_ff;
   logic [qmm_pkg::YAW_SHIFT_W-1:0]    yaw_shift_ff;
   logic [SPEED_W-1:0]                 min_speed_ff;
   logic [SPEED_W-1:0]                 speed_cap_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         thrust_shift_ff <= '0;
         yaw_shift_ff    <= '0;
         min_speed_ff    <= '0;
         speed_cap_ff    <= qmm_pkg::MAX_SPEED_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            qmm_pkg::REG_THRUST_SHIFT: begin
               thrust_shift_ff <= csr_wdata[qmm_pkg::THRUST_SHIFT_W-1:0];
            end
            qmm_pkg::REG_YAW_SHIFT: begin
               yaw_shift_ff <= csr_wdata[qmm_pkg::YAW_SHIFT_W-1:0];
            end
            qmm_pkg::REG_MIN_SPEED: begin
               min_speed_ff <= csr_wdata[SPEED_W-1:0];
            end
            qmm_pkg::REG_MAX_SPEED: begin
               speed_cap_ff <= csr_wdata[SPEED_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // ------------------------------------------------------------------
   // Handshake and valid/zero-lift pipeline
   // ------------------------------------------------------------------
   logic              accept;
   logic [PIPE_D-1:0] valid_ff;
   logic [PIPE_D-1:0] zero_ff;
   logic              rsp_valid_ff;

   assign busy   = reset;
   assign accept = start && !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         valid_ff     <= {valid_ff[PIPE_D-2:0], accept};
         rsp_valid_ff <= valid_ff[PIPE_D-1];
      end
   end

   always_ff @(posedge clock) begin
      zero_ff <= {zero_ff[PIPE_D-2:0], req_data.stick_lift_zero};
   end

   // ------------------------------------------------------------------
   // Stage 1: scale the demands and halve lift and yaw
   // ------------------------------------------------------------------
   logic        [HALF_LIFT_W-1:0] half_lift_ff, half_lift_in;
   logic signed [FIELD_W-1:0]     roll_ff, roll_in;
   logic signed [FIELD_W-1:0]     pitch_ff, pitch_in;
   logic signed [HALF_YAW_W-1:0]  half_yaw_ff, half_yaw_in;
   logic        [FIELD_W-1:0]     lift_sh;
   logic signed [YAW_EXT_W-1:0]   yaw_ext;
   logic signed [YAW_EXT_W-1:0]   yaw_sh;

   always_comb begin
      lift_sh      = req_data.lift >> thrust_shift_ff;
      half_lift_in = lift_sh[FIELD_W-1:1];
      roll_in      = req_data.roll_moment >>> thrust_shift_ff;
      pitch_in     = req_data.pitch_moment >>> thrust_shift_ff;
      yaw_ext      = YAW_EXT_W'(req_data.yaw_moment);
      yaw_sh       = yaw_ext <<< yaw_shift_ff;
      // Dropping the low bit of a signed value is a floor halving.
      half_yaw_in  = yaw_sh[YAW_EXT_W-1:1];
   end

   always_ff @(posedge clock) begin
      half_lift_ff <= half_lift_in;
      roll_ff      <= roll_in;
      pitch_ff     <= pitch_in;
      half_yaw_ff  <= half_yaw_in;
   end

   // ------------------------------------------------------------------
   // Stage 2: four squared-speed sums, halved and clamped at zero
   // ------------------------------------------------------------------
   logic [RAD_W-1:0]        rad_ff [MOTORS];
   logic [RAD_W-1:0]        rad_in [MOTORS];
   logic signed [SUM_W-1:0] sum    [MOTORS];

   always_comb begin
      logic signed [SUM_W-1:0] ez;
      logic signed [SUM_W-1:0] el;
      logic signed [SUM_W-1:0] em;
      logic signed [SUM_W-1:0] en;
      ez = SUM_W'(half_lift_ff);
      el = SUM_W'(roll_ff);
      em = SUM_W'(pitch_ff);
      en = SUM_W'(half_yaw_ff);
      sum[0] = em + en + ez;
      sum[1] = ez - en - el;
      sum[2] = ez + en - em;
      sum[3] = el - en + ez;
      for (int i = 0; i < MOTORS; i++) begin
         if (sum[i][SUM_W-1]) begin
            rad_in[i] = '0;
         end else begin
            rad_in[i] = RAD_W'(sum[i][SUM_W-1:1]);
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < MOTORS; i++) begin
         rad_ff[i] <= rad_in[i];
      end
   end

   // ------------------------------------------------------------------
   // Square-root lanes
   // ------------------------------------------------------------------
   logic [ROOT_W-1:0] root [MOTORS];

   for (genvar g = 0; g < MOTORS; g++) begin : g_lane
      qmm_sqrt_pipe #(
         .STEPS (SQRT_STEPS)
      ) u_sqrt (
         .clock  (clock),
         .rad_i  (rad_ff[g]),
         .root_o (root[g])
      );
   end

   // ------------------------------------------------------------------
   // Output stage: minimum, then maximum, forced to zero without lift
   // ------------------------------------------------------------------
   logic [SPEED_W-1:0] speed [MOTORS];
   qmm_pkg::rsp_type   rsp_ff, rsp_in;

   always_comb begin
      logic [SPEED_W-1:0] s;
      for (int i = 0; i < MOTORS; i++) begin
         s = SPEED_W'(root[i]);
         if (s < min_speed_ff) begin
            s = min_speed_ff;
         end
         if (s > speed_cap_ff) begin
            s = speed_cap_ff;
         end
         speed[i] = zero_ff[PIPE_D-1] ? '0 : s;
      end
      rsp_in.motor_0 = speed[0];
      rsp_in.motor_1 = speed[1];
      rsp_in.motor_2 = speed[2];
      rsp_in.motor_3 = speed[3];
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef SYNTHESIS
   // Every accepted request produces exactly one response.
   a_latency: assert property (@(posedge clock) disable iff (reset)
      rsp_valid == $past(accept, LATENCY))
      else $error("response strobe does not match request latency");

   // The cap is applied after the minimum, so no speed exceeds the maximum in force.
   a_max_cap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.motor_0 <= $past(speed_cap_ff)) &&
                    (rsp_data.motor_1 <= $past(speed_cap_ff)) &&
                    (rsp_data.motor_2 <= $past(speed_cap_ff)) &&
                    (rsp_data.motor_3 <= $past(speed_cap_ff)))
      else $error("motor speed above maximum");

   // A request without stick lift must come out as all-zero speeds.
   a_zero_lift: assert property (@(posedge clock) disable iff (reset)
      (valid_ff[PIPE_D-1] && zero_ff[PIPE_D-1]) |=>
         (rsp_valid && (rsp_data.motor_0 == '0) && (rsp_data.motor_1 == '0) &&
          (rsp_data.motor_2 == '0) && (rsp_data.motor_3 == '0)))
      else $error("zero-lift request produced nonzero speed");
`endif

endmodule
